// ----- src/sacd_pkg.sv -----
// package for the set-associative cache directory: constants, types, policy codes
`default_nettype none
package sacd_pkg;
    localparam int SETS_DEF = 64;
    localparam int WAYS_DEF = 4;
    localparam int BLOCK_BYTES_DEF = 16;
    localparam int AGE_BITS_DEF = 4;
    localparam logic [15:0] LFSR_MASK = 16'hB400;

    typedef enum logic [1:0] {
        POL_LRU = 2'd0,
        POL_FIFO = 2'd1,
        POL_RANDOM = 2'd2,
        POL_LFU = 2'd3
    } policy_t;

    typedef enum logic [0:0] {
        REG_POLICY = 1'b0,
        REG_SEED = 1'b1
    } reg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_SCAN,
        ST_UPDATE,
        ST_OUT
    } state_t;
endpackage
`default_nettype wire

// ----- src/set_assoc_cache_directory_core.sv -----
// top level of the set-associative cache directory
//
//  channel | ports                                   | direction
//  request | s_valid s_ready s_address s_is_write    | in
//  result  | m_valid m_ready m_hit m_hit_way m_fill   | out
//          | m_writeback m_victim_block_address      |
//  config  | psel penable pwrite paddr pwdata prdata | APB
//
// a request runs through ST_READ, ST_SCAN, ST_UPDATE and ST_OUT before the next accept:
// ST_READ reads the set one way per cycle through the single line memory read port,
// ST_SCAN picks the way and victim, ST_UPDATE writes the set back one way per cycle,
// ST_OUT presents the result, and s_ready rises again in ST_IDLE.
// reset clears valid flags at once, no clearing pass. s_ready is low while a
// request is in work or its result waits; m_ready low holds the result in ST_OUT.
`default_nettype none
module set_assoc_cache_directory_core import sacd_pkg::*; #(
    parameter int SETS = SETS_DEF,
    parameter int WAYS = WAYS_DEF,
    parameter int BLOCK_BYTES = BLOCK_BYTES_DEF,
    parameter int AGE_BITS = AGE_BITS_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [31:0] s_address,
    input  wire logic        s_is_write,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic             m_hit,
    output logic [1:0]       m_hit_way,
    output logic             m_fill,
    output logic             m_writeback,
    output logic [31:0]      m_victim_block_address,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    localparam int OFF_W = $clog2(BLOCK_BYTES);
    localparam int SET_W = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int SET_B = $clog2(SETS);
    localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int LINES = SETS * WAYS;
    localparam int LINE_W = $clog2(LINES) > 0 ? $clog2(LINES) : 1;
    localparam int TAG_W = 32 - OFF_W - SET_B;
    localparam int CNT_W = AGE_BITS;
    localparam logic [CNT_W-1:0] CNT_MAX = '1;
    localparam int WC_W = $clog2(WAYS + 1);

    // configuration registers
    logic [1:0] policy_reg;
    logic [15:0] seed_reg;
    logic [15:0] lfsr_reg, lfsr_next;
    logic cfg_wr;
    assign cfg_wr = psel & penable & pwrite;
    assign pready = 1'b1;

    always_comb begin
        unique case (paddr[2])
            REG_POLICY: prdata = {30'd0, policy_reg};
            REG_SEED:   prdata = {16'd0, seed_reg};
            default:    prdata = '0;
        endcase
    end

    // request registers and working state
    state_t state_reg, state_next;
    logic [TAG_W-1:0] tag_reg;
    logic [SET_W-1:0] set_reg;
    logic wr_reg;
    logic [WC_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_buf [WAYS];
    logic [WAYS-1:0] valid_buf, dirty_buf;
    logic [TAG_W-1:0] tag_buf [WAYS];
    logic hit_reg, wb_reg, found_reg;
    logic [WAY_W-1:0] way_reg, inv_reg, least_reg;
    logic [31:0] vaddr_reg;

    logic [LINE_W-1:0] rd_addr, wr_addr;
    logic [TAG_W-1:0] rd_tag;
    logic rd_valid, rd_dirty;
    logic [CNT_W-1:0] rd_cnt, wr_cnt;
    logic wr_en;
    logic [WAY_W-1:0] idx;

    assign idx = cnt_reg[WAY_W-1:0];

    function automatic logic [LINE_W-1:0] line_of(logic [SET_W-1:0] s, logic [WAY_W-1:0] w);
        logic [31:0] v;
        v = 32'(s) * 32'(WAYS) + 32'(w);
        return v[LINE_W-1:0];
    endfunction

    assign rd_addr = line_of(set_reg, idx);
    assign wr_addr = line_of(set_reg, idx);

    sacd_way_mem #(.LINES(LINES), .TAG_W(TAG_W), .CNT_W(CNT_W)) u_mem (
        .aclk(aclk), .aresetn(aresetn),
        .rd_addr(rd_addr), .rd_tag(rd_tag), .rd_valid(rd_valid),
        .rd_dirty(rd_dirty), .rd_cnt(rd_cnt),
        .wr_en(wr_en), .wr_addr(wr_addr), .wr_tag(tag_buf[idx]),
        .wr_valid(valid_buf[idx]), .wr_dirty(dirty_buf[idx]), .wr_cnt(wr_cnt)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (s_valid) state_next = ST_READ;
            ST_READ:   if (cnt_reg == WC_W'(WAYS)) state_next = ST_SCAN;
            ST_SCAN:   state_next = ST_UPDATE;
            ST_UPDATE: if (cnt_reg == WC_W'(WAYS - 1)) state_next = ST_OUT;
            ST_OUT:    if (m_ready) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        s_ready = (state_reg == ST_IDLE);
        m_valid = (state_reg == ST_OUT);
        wr_en = (state_reg == ST_UPDATE);
    end

    // counter value written back for the way at idx
    logic touch, hit_w, sel_w;
    always_comb begin
        sel_w = (idx == way_reg);
        hit_w = hit_reg;
        touch = 1'b0;
        wr_cnt = cnt_buf[idx];
        if (hit_w) begin
            if (policy_reg == POL_LRU) touch = 1'b1;
            else if (policy_reg == POL_LFU && sel_w && cnt_buf[idx] != CNT_MAX)
                wr_cnt = cnt_buf[idx] + 1'b1;
        end else begin
            if (policy_reg == POL_LRU || policy_reg == POL_FIFO) touch = 1'b1;
            else if (sel_w && policy_reg == POL_RANDOM) wr_cnt = '0;
            else if (sel_w) wr_cnt = CNT_W'(1);
        end
        if (touch && cnt_buf[way_reg] != CNT_MAX) begin
            if (sel_w) wr_cnt = CNT_MAX;
            else if (cnt_buf[idx] != '0) wr_cnt = cnt_buf[idx] - 1'b1;
        end
    end

    // random step
    always_comb begin
        lfsr_next = lfsr_reg >> 1;
        if (lfsr_reg[0]) lfsr_next = lfsr_next ^ LFSR_MASK;
    end

    logic [SET_W-1:0] in_set;
    logic [TAG_W-1:0] in_tag;
    assign in_set = (SETS > 1) ? SET_W'(s_address >> OFF_W) : '0;
    assign in_tag = TAG_W'(s_address >> (OFF_W + SET_B));

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            policy_reg <= POL_LRU;
            seed_reg <= 16'd1;
            lfsr_reg <= 16'd1;
            cnt_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr && paddr[2] == REG_POLICY) policy_reg <= pwdata[1:0];
            if (cfg_wr && paddr[2] == REG_SEED) begin
                seed_reg <= pwdata[15:0];
                lfsr_reg <= (pwdata[15:0] == 16'd0) ? 16'd1 : pwdata[15:0];
            end
            if (state_reg == ST_SCAN && !hit_reg && !found_reg
                    && policy_reg == POL_RANDOM)
                lfsr_reg <= lfsr_next;
            if (state_reg == ST_IDLE || state_reg == ST_SCAN) cnt_reg <= '0;
            else if (state_reg == ST_READ || state_reg == ST_UPDATE)
                cnt_reg <= cnt_reg + 1'b1;
        end
    end

    // payload registers: gather the set one way per cycle, then decide
    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE && s_valid) begin
            tag_reg <= in_tag;
            set_reg <= in_set;
            wr_reg <= s_is_write;
            hit_reg <= 1'b0;
            found_reg <= 1'b0;
            way_reg <= '0;
            inv_reg <= '0;
            least_reg <= '0;
        end
        if (state_reg == ST_READ && cnt_reg != '0) begin
            valid_buf[WAY_W'(cnt_reg - 1'b1)] <= rd_valid;
            dirty_buf[WAY_W'(cnt_reg - 1'b1)] <= rd_dirty;
            tag_buf[WAY_W'(cnt_reg - 1'b1)] <= rd_tag;
            cnt_buf[WAY_W'(cnt_reg - 1'b1)] <= rd_cnt;
            if (!hit_reg && rd_valid && rd_tag == tag_reg) begin
                hit_reg <= 1'b1;
                way_reg <= WAY_W'(cnt_reg - 1'b1);
            end
            if (!found_reg && !rd_valid) begin
                found_reg <= 1'b1;
                inv_reg <= WAY_W'(cnt_reg - 1'b1);
            end
            if (cnt_reg != WC_W'(1) && rd_cnt < cnt_buf[least_reg])
                least_reg <= WAY_W'(cnt_reg - 1'b1);
        end
        if (state_reg == ST_SCAN) begin
            wb_reg <= 1'b0;
            vaddr_reg <= '0;
            if (hit_reg) begin
                if (wr_reg) dirty_buf[way_reg] <= 1'b1;
            end else begin
                logic [WAY_W-1:0] v;
                v = found_reg ? inv_reg :
                    (policy_reg == POL_RANDOM) ? WAY_W'(lfsr_next % WAYS) : least_reg;
                way_reg <= v;
                if (valid_buf[v] && dirty_buf[v]) begin
                    wb_reg <= 1'b1;
                    vaddr_reg <= (32'({tag_buf[v], set_reg}) >> (SET_W - SET_B))
                                 << OFF_W;
                end
                valid_buf[v] <= 1'b1;
                dirty_buf[v] <= wr_reg;
                tag_buf[v] <= tag_reg;
            end
        end
    end

    assign m_hit = hit_reg;
    assign m_hit_way = 2'(way_reg);
    assign m_fill = ~hit_reg;
    assign m_writeback = wb_reg;
    assign m_victim_block_address = vaddr_reg;

    // assertions
    a_ready_out: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid)) else $error("ready while result pending");
    a_fill_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_fill != m_hit)) else $error("fill and hit disagree");
    a_wb_miss: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_writeback) |-> !m_hit) else $error("writeback on hit");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> m_valid) else $error("result dropped");
endmodule
`default_nettype wire

// ----- src/sacd_way_mem.sv -----
// per-line storage of tag, valid, dirty and recency counter, one read and one write port
`default_nettype none
module sacd_way_mem import sacd_pkg::*; #(
    parameter int LINES = 256,
    parameter int TAG_W = 22,
    parameter int CNT_W = 4
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic [$clog2(LINES)-1:0] rd_addr,
    output logic      [TAG_W-1:0]         rd_tag,
    output logic                          rd_valid,
    output logic                          rd_dirty,
    output logic      [CNT_W-1:0]         rd_cnt,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(LINES)-1:0] wr_addr,
    input  wire logic [TAG_W-1:0]         wr_tag,
    input  wire logic                     wr_valid,
    input  wire logic                     wr_dirty,
    input  wire logic [CNT_W-1:0]         wr_cnt
);
    logic [TAG_W-1:0] tag_mem [LINES];
    logic [CNT_W-1:0] cnt_mem [LINES];
    logic             dirty_mem [LINES];
    logic [LINES-1:0] valid_reg;

    // tag, dirty and counter arrays; dirty and counter are masked by the valid flag on read
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            tag_mem[wr_addr] <= wr_tag;
            cnt_mem[wr_addr] <= wr_cnt;
            dirty_mem[wr_addr] <= wr_dirty;
        end
        rd_tag <= tag_mem[rd_addr];
        rd_cnt <= valid_reg[rd_addr] ? cnt_mem[rd_addr] : '0;
        rd_dirty <= valid_reg[rd_addr] & dirty_mem[rd_addr];
    end

    // valid flags cleared at reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (wr_en) begin
            valid_reg[wr_addr] <= wr_valid;
        end
    end

    always_ff @(posedge aclk) begin
        rd_valid <= valid_reg[rd_addr] & aresetn;
    end
endmodule
`default_nettype wire

// ----- verif/set_assoc_cache_directory_core_test.sv -----
// testbench for the set-associative cache directory core
`timescale 1ns / 100ps
`default_nettype none
module set_assoc_cache_directory_core_test;
    import sacd_pkg::*;

    localparam int NSETS = 64;
    localparam int NWAYS = 4;
    localparam int CMAX = 15;
    localparam int IDLE_LIMIT = 20000;

    typedef struct packed {
        logic [31:0] address;
        logic        is_write;
    } access_t;

    typedef struct packed {
        logic        hit;
        logic [1:0]  hit_way;
        logic        fill;
        logic        writeback;
        logic [31:0] victim_block_address;
    } lookup_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [31:0] s_address = '0;
    logic s_is_write = 1'b0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic m_hit;
    logic [1:0] m_hit_way;
    logic m_fill;
    logic m_writeback;
    logic [31:0] m_victim_block_address;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [2:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    set_assoc_cache_directory_core u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_address(s_address), .s_is_write(s_is_write),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_hit(m_hit), .m_hit_way(m_hit_way), .m_fill(m_fill),
        .m_writeback(m_writeback), .m_victim_block_address(m_victim_block_address),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // clock
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // directory shadow state
    policy_t     cur_policy;
    logic        dir_valid [NSETS*NWAYS];
    logic        dir_dirty [NSETS*NWAYS];
    logic [21:0] dir_tag [NSETS*NWAYS];
    logic [3:0]  dir_age [NSETS*NWAYS];
    logic [15:0] victim_lfsr;

    access_t pending_requests[$];
    lookup_t expected_lookups[$];
    int send_idle_pct = 35;
    int recv_idle_pct = 56;
    int hold_cycles = 0;
    int errors = 0;
    int idle_count = 0;

    task automatic shadow_reset();
        cur_policy = POL_LRU;
        victim_lfsr = 16'd1;
        for (int i = 0; i < NSETS*NWAYS; i++) begin
            dir_valid[i] = 1'b0;
            dir_dirty[i] = 1'b0;
            dir_tag[i] = '0;
            dir_age[i] = '0;
        end
    endtask

    // bump way to most recent, aging the others
    function automatic void recency_touch(int base, int w);
        if (dir_age[base+w] == CMAX) return;
        for (int i = 0; i < NWAYS; i++)
            if (i != w && dir_age[base+i] != 0) dir_age[base+i]--;
        dir_age[base+w] = CMAX;
    endfunction

    // predict one lookup and update the shadow directory
    function automatic lookup_t predict_lookup(access_t a);
        lookup_t r;
        logic [27:0] blk;
        int set, base, way, k;
        logic [21:0] tag;
        logic found;
        blk = a.address[31:4];
        set = int'(blk[5:0]);
        tag = blk[27:6];
        base = set * NWAYS;
        way = 0;
        found = 1'b0;
        r = '0;
        for (int i = 0; i < NWAYS; i++)
            if (!found && dir_valid[base+i] && dir_tag[base+i] == tag) begin
                found = 1'b1;
                way = i;
            end
        if (found) begin
            k = base + way;
            if (cur_policy == POL_LRU) recency_touch(base, way);
            else if (cur_policy == POL_LFU && dir_age[k] != CMAX) dir_age[k]++;
            if (a.is_write) dir_dirty[k] = 1'b1;
            r.hit = 1'b1;
        end else begin
            for (int i = 0; i < NWAYS; i++)
                if (!found && !dir_valid[base+i]) begin
                    found = 1'b1;
                    way = i;
                end
            if (!found) begin
                if (cur_policy == POL_RANDOM) begin
                    victim_lfsr = victim_lfsr[0] ? ((victim_lfsr >> 1) ^ LFSR_MASK)
                                                 : (victim_lfsr >> 1);
                    way = int'(victim_lfsr[1:0]);
                end else begin
                    way = 0;
                    for (int i = 1; i < NWAYS; i++)
                        if (dir_age[base+i] < dir_age[base+way]) way = i;
                end
            end
            k = base + way;
            if (dir_valid[k] && dir_dirty[k]) begin
                r.writeback = 1'b1;
                r.victim_block_address = {dir_tag[k], set[5:0], 4'b0};
            end
            dir_valid[k] = 1'b1;
            dir_dirty[k] = a.is_write;
            dir_tag[k] = tag;
            if (cur_policy == POL_LRU || cur_policy == POL_FIFO) recency_touch(base, way);
            else if (cur_policy == POL_RANDOM) dir_age[k] = '0;
            else dir_age[k] = 4'd1;
            r.fill = 1'b1;
        end
        r.hit_way = way[1:0];
        return r;
    endfunction

    // request driver
    always @(posedge aclk) begin
        if (aresetn) begin
            if (!s_valid || s_ready) begin
                if (s_valid && s_ready)
                    expected_lookups.insert(expected_lookups.size(),
                                            predict_lookup(pending_requests.pop_front()));
                if (pending_requests.size() > 0 &&
                        $urandom_range(99) >= send_idle_pct) begin
                    s_valid <= 1'b1;
                    s_address <= pending_requests[0].address;
                    s_is_write <= pending_requests[0].is_write;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor and receiver stalls
    always @(posedge aclk) begin
        lookup_t e;
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) idle_count <= 0;
            else idle_count <= idle_count + 1;
            if (m_valid && m_ready) begin
                if (expected_lookups.size() == 0) begin
                    $error("result with no request outstanding");
                    errors++;
                end else begin
                    e = expected_lookups.pop_front();
                    if (m_hit !== e.hit) begin
                        $error("hit exp %0h got %0h", e.hit, m_hit); errors++;
                    end
                    if (m_hit_way !== e.hit_way) begin
                        $error("hit_way exp %0h got %0h", e.hit_way, m_hit_way); errors++;
                    end
                    if (m_fill !== e.fill) begin
                        $error("fill exp %0h got %0h", e.fill, m_fill); errors++;
                    end
                    if (m_writeback !== e.writeback) begin
                        $error("writeback exp %0h got %0h", e.writeback, m_writeback);
                        errors++;
                    end
                    if (m_victim_block_address !== e.victim_block_address) begin
                        $error("victim_block_address exp %0h got %0h",
                               e.victim_block_address, m_victim_block_address);
                        errors++;
                    end
                end
            end
            if (hold_cycles > 0) begin
                hold_cycles <= hold_cycles - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        if (idle_count >= IDLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    task automatic reg_write(reg_idx_t idx, logic [31:0] val);
        @(posedge aclk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {idx, 2'b00}; pwdata <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        if (idx == REG_POLICY) cur_policy = policy_t'(val[1:0]);
        else victim_lfsr = (val[15:0] == 0) ? 16'd1 : val[15:0];
    endtask

    task automatic drain();
        while (pending_requests.size() != 0 || s_valid || expected_lookups.size() != 0)
            @(posedge aclk);
        repeat (30) @(posedge aclk);
    endtask

    // append one request to the pending list
    task automatic queue_request(access_t a);
        pending_requests.insert(pending_requests.size(), a);
    endtask

    // mostly a few sets and a small pool of tags so sets fill and evict
    function automatic access_t random_access();
        access_t a;
        a.address = $urandom;
        a.is_write = 1'($urandom_range(1));
        if ($urandom_range(9) < 8)
            a.address = {16'h0, 4'($urandom_range(7)), 2'b00, 6'($urandom_range(3)),
                         a.address[3:0]};
        return a;
    endfunction

    task automatic queue_random(int n);
        for (int i = 0; i < n; i++) queue_request(random_access());
    endtask

    initial begin
        policy_t pols [4];
        logic [15:0] seeds [4];
        pols = '{POL_LRU, POL_FIFO, POL_RANDOM, POL_LFU};
        seeds = '{16'h0001, 16'hFFFF, 16'h0000, 16'hACE1};
        shadow_reset();
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        // directed: extremes and conflict evictions in set 0, dirty victims
        queue_request(access_t'{32'h0000_0000, 1'b0});
        queue_request(access_t'{32'hFFFF_FFFF, 1'b1});
        queue_request(access_t'{32'hFFFF_FFF0, 1'b0});
        for (int t = 0; t < 6; t++)
            queue_request(access_t'{32'(t) << 10, 1'(t[0])});
        queue_request(access_t'{32'h0000_0400, 1'b0});
        queue_request(access_t'{32'hAAAA_AAAA, 1'b1});
        queue_request(access_t'{32'h5555_5555, 1'b0});
        drain();
        for (int p = 0; p < 8; p++) begin
            reg_write(REG_POLICY, {30'b0, pols[p % 4]});
            reg_write(REG_SEED, {16'b0, seeds[p % 4]});
            send_idle_pct = (p < 3) ? 35 : (p < 6) ? 56 : 0;
            recv_idle_pct = (p < 3) ? 56 : (p < 6) ? 35 : 0;
            // directed conflict sweep in one set, then random
            for (int t = 0; t < 6; t++)
                queue_request(access_t'{(32'(t) << 10) | 32'h10, 1'b1});
            if (p == 6) hold_cycles = 400;
            queue_random(140);
            drain();
        end
        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule
`default_nettype wire
